// File: rtl/spst_pkg.sv
// Shared constants, types and helpers for the spring particle step pipeline.
`timescale 1ns / 1ps

package spst_pkg;

  // Fixed point formats
  localparam int FRAC_BITS = 16;
  localparam int DT_BITS   = 16;
  localparam int DT_W      = 12;
  localparam logic [DT_W-1:0] DT_MAX = 12'd3277;

  // Repulsion arithmetic widths
  localparam int AD_W    = 27;                 // |dx| while inside the radius
  localparam int D2_W    = 2 * AD_W + 1;       // dx^2 + dy^2
  localparam int SQ_IN_W = D2_W + 1;           // even width for the root
  localparam int SQ_W    = SQ_IN_W / 2;        // root bits, one per stage
  localparam int NUM_W   = AD_W + FRAC_BITS;   // dividend width
  localparam int DEN_W   = D2_W - FRAC_BITS;   // divisor width
  localparam int QUO_W   = 30;                 // quotient bits, one per stage

  localparam logic [NUM_W-1:0] PUSH_NUM = NUM_W'(2000) << (2 * FRAC_BITS);
  localparam logic [D2_W-1:0]  HALF2    = D2_W'(1) << (2 * FRAC_BITS - 2);

  // Register map (word index)
  localparam logic [1:0] REG_SPRING = 2'd0;
  localparam logic [1:0] REG_DAMP   = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic [22:0] SPRING_RST = 23'd393216;
  localparam logic [22:0] DAMP_RST   = 23'd196608;
  localparam logic [26:0] RADIUS_RST = 27'd7864320;

  typedef struct packed {
    logic [22:0] spring_gain;
    logic [22:0] damping_gain;
    logic [26:0] repel_radius;
  } cfg_t;

  // Per-item data that rides alongside the root and divider pipes
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [DT_W-1:0]    dt;
    logic               neg_x;
    logic               neg_y;
    logic               pe;
    logic signed [41:0] bx;
    logic signed [41:0] by;
    logic [AD_W-1:0]    adx;
    logic [AD_W-1:0]    ady;
  } sb_t;

  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    if (v > 44'sd2147483647) return 32'sh7fffffff;
    if (v < -44'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// File: rtl/spst_if.sv
// Item channel interfaces: particle in, stepped particle out.
`timescale 1ns / 1ps

interface spst_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] home_x;
  logic signed [31:0] home_y;
  logic signed [31:0] pointer_x;
  logic signed [31:0] pointer_y;
  logic [15:0]        time_step;
  modport source(output valid, pos_x, pos_y, vel_x, vel_y, home_x, home_y,
                 pointer_x, pointer_y, time_step, input ready);
  modport sink(input valid, pos_x, pos_y, vel_x, vel_y, home_x, home_y,
               pointer_x, pointer_y, time_step, output ready);
endinterface

interface spst_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  modport source(output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                 input ready);
  modport sink(input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
               output ready);
endinterface

// File: rtl/spst_cfg_regs.sv
// APB register block for spring gain, damping gain and repel radius.
`timescale 1ns / 1ps

module spst_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output spst_pkg::cfg_t     cfg
);

  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spring_gain  <= spst_pkg::SPRING_RST;
      cfg.damping_gain <= spst_pkg::DAMP_RST;
      cfg.repel_radius <= spst_pkg::RADIUS_RST;
    end else if (wr) begin
      case (idx)
        spst_pkg::REG_SPRING: cfg.spring_gain  <= pwdata[22:0];
        spst_pkg::REG_DAMP:   cfg.damping_gain <= pwdata[22:0];
        spst_pkg::REG_RADIUS: cfg.repel_radius <= pwdata[26:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      spst_pkg::REG_SPRING: prdata = {9'b0, cfg.spring_gain};
      spst_pkg::REG_DAMP:   prdata = {9'b0, cfg.damping_gain};
      spst_pkg::REG_RADIUS: prdata = {5'b0, cfg.repel_radius};
      default:              prdata = '0;
    endcase
  end

endmodule

// File: rtl/spst_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps

module spst_sqrt_pipe (
  input  logic                          clk,
  input  logic                          en,
  input  logic [spst_pkg::SQ_IN_W-1:0]  rad,
  output logic [spst_pkg::SQ_W-1:0]     root
);

  logic [spst_pkg::SQ_IN_W-1:0] rem_q  [0:spst_pkg::SQ_W-1];
  logic [spst_pkg::SQ_W-1:0]    root_q [0:spst_pkg::SQ_W-1];

  for (genvar i = 0; i < spst_pkg::SQ_W; i++) begin : g_stage
    localparam int B = spst_pkg::SQ_W - 1 - i;
    logic [spst_pkg::SQ_IN_W-1:0] rem_in;
    logic [spst_pkg::SQ_W-1:0]    root_in;
    logic [spst_pkg::SQ_IN_W-1:0] term;

    if (i == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    // (root + 2^B)^2 - root^2; root holds no bits at or below B
    assign term = (spst_pkg::SQ_IN_W'(root_in) << (B + 1)) |
                  (spst_pkg::SQ_IN_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= term) begin
          rem_q[i]  <= rem_in - term;
          root_q[i] <= root_in | (spst_pkg::SQ_W'(1) << B);
        end else begin
          rem_q[i]  <= rem_in;
          root_q[i] <= root_in;
        end
      end
    end
  end

  assign root = root_q[spst_pkg::SQ_W-1];

endmodule

// File: rtl/spst_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module spst_div_pipe (
  input  logic                        clk,
  input  logic                        en,
  input  logic [spst_pkg::NUM_W-1:0]  num,
  input  logic [spst_pkg::DEN_W-1:0]  den,
  output logic [spst_pkg::QUO_W-1:0]  quo
);

  logic [spst_pkg::NUM_W-1:0] rem_q [0:spst_pkg::QUO_W-1];
  logic [spst_pkg::DEN_W-1:0] den_q [0:spst_pkg::QUO_W-1];
  logic [spst_pkg::QUO_W-1:0] quo_q [0:spst_pkg::QUO_W-1];

  for (genvar i = 0; i < spst_pkg::QUO_W; i++) begin : g_stage
    localparam int B = spst_pkg::QUO_W - 1 - i;
    logic [spst_pkg::NUM_W-1:0] rem_in;
    logic [spst_pkg::DEN_W-1:0] den_in;
    logic [spst_pkg::QUO_W-1:0] quo_in;
    logic [spst_pkg::NUM_W-1:0] den_w;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    assign den_w = spst_pkg::NUM_W'(den_in);

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[i] <= den_in;
        if ((rem_in >> B) >= den_w) begin
          rem_q[i] <= rem_in - (den_w << B);
          quo_q[i] <= quo_in | (spst_pkg::QUO_W'(1) << B);
        end else begin
          rem_q[i] <= rem_in;
          quo_q[i] <= quo_in;
        end
      end
    end
  end

  assign quo = quo_q[spst_pkg::QUO_W-1];

endmodule

// File: rtl/spring_particle_step.sv
// Top level: spring-damper particle step with pointer repulsion, fully pipelined.
`timescale 1ns / 1ps

// One particle enters per clock unless the pipe is stalled, and its stepped position
// and velocity leave at the output; throughput is one item per cycle outside stalls.
// The square-root pipe (28 stages) feeds the direction dividers (30 stages), plus ten
// stages of differences, products, sums and the two Euler updates.
// The push magnitude divider runs beside the square root. The whole pipe
// advances together: when a finished item is held at the output because the
// sink is not ready, every stage holds and the input is not ready. Registers
// are written over the APB port and must only change while the pipe is empty.
module spring_particle_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  spst_in_if.sink     particle,
  spst_out_if.source  result
);

  localparam int NST   = 68;   // total register stages
  localparam int SB_N  = 64;   // sideband line, entry 0 loads together with r4_d2
  localparam int MAG_N = 28;   // extra delay for the push magnitude

  spst_pkg::cfg_t cfg;
  logic           en;
  logic [NST-1:0] vld;

  spst_cfg_regs u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  // Global advance: move whenever the output slot is free or being taken
  assign en             = !vld[NST-1] || result.ready;
  assign particle.ready = en;
  assign result.valid   = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], particle.valid};
    end
  end

  // Stage 1: differences and clamped time step
  logic signed [31:0] r1_px, r1_py, r1_vx, r1_vy;
  logic signed [32:0] r1_dx, r1_dy, r1_ex, r1_ey;
  logic [spst_pkg::DT_W-1:0] r1_dt;

  always_ff @(posedge clk) begin
    if (en) begin
      r1_px <= particle.pos_x;
      r1_py <= particle.pos_y;
      r1_vx <= particle.vel_x;
      r1_vy <= particle.vel_y;
      r1_dx <= 33'(particle.pos_x) - 33'(particle.pointer_x);
      r1_dy <= 33'(particle.pos_y) - 33'(particle.pointer_y);
      r1_ex <= 33'(particle.home_x) - 33'(particle.pos_x);
      r1_ey <= 33'(particle.home_y) - 33'(particle.pos_y);
      r1_dt <= (particle.time_step > 16'(spst_pkg::DT_MAX)) ? spst_pkg::DT_MAX
                                                           : particle.time_step[11:0];
    end
  end

  // Stage 2: magnitudes, radius box test, spring and damping products
  logic [32:0] adx33, ady33;
  logic signed [31:0] r2_px, r2_py, r2_vx, r2_vy;
  logic [spst_pkg::DT_W-1:0] r2_dt;
  logic [spst_pkg::AD_W-1:0] r2_adx, r2_ady;
  logic r2_negx, r2_negy, r2_inr;
  logic signed [56:0] r2_spx, r2_spy;
  logic signed [55:0] r2_dmx, r2_dmy;

  assign adx33 = r1_dx[32] ? 33'(-r1_dx) : 33'(r1_dx);
  assign ady33 = r1_dy[32] ? 33'(-r1_dy) : 33'(r1_dy);

  always_ff @(posedge clk) begin
    if (en) begin
      r2_px   <= r1_px;
      r2_py   <= r1_py;
      r2_vx   <= r1_vx;
      r2_vy   <= r1_vy;
      r2_dt   <= r1_dt;
      r2_adx  <= adx33[spst_pkg::AD_W-1:0];
      r2_ady  <= ady33[spst_pkg::AD_W-1:0];
      r2_negx <= r1_dx[32];
      r2_negy <= r1_dy[32];
      r2_inr  <= (adx33 < 33'(cfg.repel_radius)) && (ady33 < 33'(cfg.repel_radius));
      r2_spx  <= r1_ex * $signed({1'b0, cfg.spring_gain});
      r2_spy  <= r1_ey * $signed({1'b0, cfg.spring_gain});
      r2_dmx  <= r1_vx * $signed({1'b0, cfg.damping_gain});
      r2_dmy  <= r1_vy * $signed({1'b0, cfg.damping_gain});
    end
  end

  // Stage 3: squares, radius squared, base force (floor shifts)
  logic signed [31:0] r3_px, r3_py, r3_vx, r3_vy;
  logic [spst_pkg::DT_W-1:0] r3_dt;
  logic [spst_pkg::AD_W-1:0] r3_adx, r3_ady;
  logic r3_negx, r3_negy, r3_inr;
  logic [2*spst_pkg::AD_W-1:0] r3_sqx, r3_sqy, r3_rsq;
  logic signed [41:0] r3_bx, r3_by;

  always_ff @(posedge clk) begin
    if (en) begin
      r3_px   <= r2_px;
      r3_py   <= r2_py;
      r3_vx   <= r2_vx;
      r3_vy   <= r2_vy;
      r3_dt   <= r2_dt;
      r3_adx  <= r2_adx;
      r3_ady  <= r2_ady;
      r3_negx <= r2_negx;
      r3_negy <= r2_negy;
      r3_inr  <= r2_inr;
      r3_sqx  <= r2_adx * r2_adx;
      r3_sqy  <= r2_ady * r2_ady;
      r3_rsq  <= cfg.repel_radius * cfg.repel_radius;
      r3_bx   <= 42'(r2_spx >>> spst_pkg::FRAC_BITS) - 42'(r2_dmx >>> spst_pkg::FRAC_BITS);
      r3_by   <= 42'(r2_spy >>> spst_pkg::FRAC_BITS) - 42'(r2_dmy >>> spst_pkg::FRAC_BITS);
    end
  end

  // Stage 4: distance squared and the push window test
  logic [spst_pkg::D2_W-1:0] d2, r4_d2;
  spst_pkg::sb_t             sb_in;
  spst_pkg::sb_t             sb [0:SB_N-1];

  assign d2 = spst_pkg::D2_W'(r3_sqx) + spst_pkg::D2_W'(r3_sqy);

  always_comb begin
    sb_in.px    = r3_px;
    sb_in.py    = r3_py;
    sb_in.vx    = r3_vx;
    sb_in.vy    = r3_vy;
    sb_in.dt    = r3_dt;
    sb_in.neg_x = r3_negx;
    sb_in.neg_y = r3_negy;
    sb_in.pe    = r3_inr && (d2 < spst_pkg::D2_W'(r3_rsq)) && (d2 > spst_pkg::HALF2);
    sb_in.bx    = r3_bx;
    sb_in.by    = r3_by;
    sb_in.adx   = r3_adx;
    sb_in.ady   = r3_ady;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r4_d2 <= d2;
      sb[0] <= sb_in;
      for (int i = 1; i < SB_N; i++) sb[i] <= sb[i-1];
    end
  end

  // Root of d2 and push magnitude 2000 / d2 run side by side
  logic [spst_pkg::SQ_W-1:0]  root;
  logic [spst_pkg::QUO_W-1:0] mag_q;
  logic [spst_pkg::QUO_W-1:0] magd [0:MAG_N-1];

  spst_sqrt_pipe u_sqrt (
    .clk(clk), .en(en), .rad({1'b0, r4_d2}), .root(root)
  );

  spst_div_pipe u_div_mag (
    .clk(clk), .en(en), .num(spst_pkg::PUSH_NUM),
    .den(r4_d2[spst_pkg::D2_W-1:spst_pkg::FRAC_BITS]), .quo(mag_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      magd[0] <= mag_q;
      for (int i = 1; i < MAG_N; i++) magd[i] <= magd[i-1];
    end
  end

  // Unit direction |d| / s, one divider per axis
  logic [spst_pkg::QUO_W-1:0] ux, uy;

  spst_div_pipe u_div_ux (
    .clk(clk), .en(en), .num({sb[28].adx, spst_pkg::FRAC_BITS'(0)}),
    .den(spst_pkg::DEN_W'(root)), .quo(ux)
  );

  spst_div_pipe u_div_uy (
    .clk(clk), .en(en), .num({sb[28].ady, spst_pkg::FRAC_BITS'(0)}),
    .den(spst_pkg::DEN_W'(root)), .quo(uy)
  );

  // Push product, force sum, Euler velocity and position updates
  logic [2*spst_pkg::QUO_W-1:0] r5_px, r5_py;
  logic signed [42:0] pvx, pvy, ptx, pty;
  logic signed [31:0] r6_fx, r6_fy;
  logic signed [44:0] r7_mx, r7_my;
  logic signed [31:0] r8_nvx, r8_nvy;
  logic signed [44:0] r9_mx, r9_my;
  logic signed [31:0] r9_nvx, r9_nvy;
  logic signed [31:0] o_px, o_py, o_vx, o_vy;

  assign pvx = $signed({11'b0, r5_px[47:16]});
  assign pvy = $signed({11'b0, r5_py[47:16]});
  assign ptx = !sb[59].pe ? 43'sd0 : (sb[59].neg_x ? -pvx : pvx);
  assign pty = !sb[59].pe ? 43'sd0 : (sb[59].neg_y ? -pvy : pvy);

  always_ff @(posedge clk) begin
    if (en) begin
      r5_px  <= ux * magd[MAG_N-1];
      r5_py  <= uy * magd[MAG_N-1];
      r6_fx  <= spst_pkg::sat32(44'(43'(sb[59].bx) + ptx));
      r6_fy  <= spst_pkg::sat32(44'(43'(sb[59].by) + pty));
      r7_mx  <= r6_fx * $signed({1'b0, sb[60].dt});
      r7_my  <= r6_fy * $signed({1'b0, sb[60].dt});
      r8_nvx <= spst_pkg::sat32(44'(sb[61].vx) + 44'(r7_mx >>> spst_pkg::DT_BITS));
      r8_nvy <= spst_pkg::sat32(44'(sb[61].vy) + 44'(r7_my >>> spst_pkg::DT_BITS));
      r9_mx  <= r8_nvx * $signed({1'b0, sb[62].dt});
      r9_my  <= r8_nvy * $signed({1'b0, sb[62].dt});
      r9_nvx <= r8_nvx;
      r9_nvy <= r8_nvy;
      o_px   <= spst_pkg::sat32(44'(sb[63].px) + 44'(r9_mx >>> spst_pkg::DT_BITS));
      o_py   <= spst_pkg::sat32(44'(sb[63].py) + 44'(r9_my >>> spst_pkg::DT_BITS));
      o_vx   <= r9_nvx;
      o_vy   <= r9_nvy;
    end
  end

  assign result.new_pos_x = o_px;
  assign result.new_pos_y = o_py;
  assign result.new_vel_x = o_vx;
  assign result.new_vel_y = o_vy;

  // Checks
  a_rst_clear: assert property (@(posedge clk) rst |=> vld == '0)
    else $error("valid bits not cleared by reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipe moved during a stall");

  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    vld[61] && sb[58].pe |-> (ux <= 30'd65536) && (uy <= 30'd65536))
    else $error("direction component above one");

  a_mag_bound: assert property (@(posedge clk) disable iff (rst)
    vld[61] && sb[58].pe |-> magd[MAG_N-1] <= 30'd524288000)
    else $error("push magnitude out of range");

endmodule
